// ----- rtl/mono_framebuffer_gray_scanout_assert.svh -----
// assertion macros for the gray scan-out frame store checker
// expects a clock named clk and an active-high reset named rst in scope
`ifndef MONO_FRAMEBUFFER_GRAY_SCANOUT_ASSERT_SVH
`define MONO_FRAMEBUFFER_GRAY_SCANOUT_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define MFGS_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define MFGS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/mfgs_pkg.sv -----
// shared types, constants and helpers for the gray scan-out frame store
// no dependencies
package mfgs_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
  localparam int HALF_WIDTH    = (SCREEN_WIDTH + 1) / 2;
  localparam int BANK_DEPTH    = HALF_WIDTH * PAGE_COUNT;
  localparam int ADDR_W        = $clog2(BANK_DEPTH);
  localparam int ROWS_PER_PAGE = 8;

  localparam logic [1:0] ACT_PLOT  = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_SCAN  = 2'd2;

  localparam logic [1:0] MODE_SET    = 2'd0;
  localparam logic [1:0] MODE_CLEAR  = 2'd1;
  localparam logic [1:0] MODE_INVERT = 2'd2;

  localparam logic [3:0] NIBBLE_LIT = 4'hF;

  typedef logic [ADDR_W-1:0] addr_t;

  // one access to both column banks (even and odd columns)
  typedef struct packed {
    logic       rd_en;
    addr_t      rd_addr;
    logic       wr_even;
    logic       wr_odd;
    addr_t      wr_addr;
    logic [7:0] wr_data;
  } mem_req_t;

  // column byte pair handed to the output stage
  typedef struct packed {
    logic       load;
    logic [7:0] left;
    logic [7:0] right;
  } gray_load_t;

  // bank entry of a column within a page
  function automatic addr_t bank_addr(input logic [11:0] col, input logic [8:0] page);
    logic [22:0] full;
    full = 23'(page) * 23'(HALF_WIDTH) + 23'(col >> 1);
    return full[ADDR_W-1:0];
  endfunction

endpackage

// ----- rtl/mfgs_frame_mem.sv -----
// frame store split into an even-column bank and an odd-column bank
// depends on mfgs_pkg
module mfgs_frame_mem (
  input  logic             clk,
  input  mfgs_pkg::mem_req_t req,
  output logic [7:0]       rd_even,
  output logic [7:0]       rd_odd
);

  logic [7:0] even_bank [mfgs_pkg::BANK_DEPTH];
  logic [7:0] odd_bank  [mfgs_pkg::BANK_DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_even) begin
      even_bank[req.wr_addr] <= req.wr_data;
    end
    if (req.wr_odd) begin
      odd_bank[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_even <= even_bank[req.rd_addr];
      rd_odd  <= odd_bank[req.rd_addr];
    end
  end

endmodule

// ----- rtl/mfgs_gray_out.sv -----
// output stage: holds one column byte pair and emits eight gray bytes
// depends on mfgs_pkg
module mfgs_gray_out (
  input  logic                 clk,
  input  logic                 rst,
  input  mfgs_pkg::gray_load_t ld,
  output logic                 busy,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           gray_byte,
  output logic                 last_byte
);

  logic [7:0] left_bits;
  logic [7:0] right_bits;
  logic [2:0] row;
  logic       take;

  assign take = busy && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      row  <= '0;
    end else if (ld.load) begin
      busy <= 1'b1;
      row  <= '0;
    end else if (take) begin
      row <= row + 3'd1;
      if (last_byte) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld.load) begin
      left_bits  <= ld.left;
      right_bits <= ld.right;
    end else if (take) begin
      left_bits  <= left_bits >> 1;
      right_bits <= right_bits >> 1;
    end
  end

  assign out_valid = busy;
  assign last_byte = (row == 3'(mfgs_pkg::ROWS_PER_PAGE - 1));
  assign gray_byte = {(left_bits[0] ? mfgs_pkg::NIBBLE_LIT : 4'h0),
                      (right_bits[0] ? mfgs_pkg::NIBBLE_LIT : 4'h0)};

endmodule

// ----- rtl/mono_framebuffer_gray_scanout.sv -----
// top level of the monochrome frame store with 4-bit gray scan-out
// depends on mfgs_pkg, mfgs_frame_mem and mfgs_gray_out
//
// The frame store is held in two synchronous RAMs of BANK_DEPTH bytes (512 at
// 128x64), one for even columns and one for odd columns, so that a column pair
// is read in a single access. After reset the block sweeps both RAMs to zero,
// one entry a cycle, and keeps in_stall high meanwhile. A plot transaction
// does the RAM read in the accept cycle, then the modify and write-back in
// ST_PLOT_WR, during which in_stall is high. A clear transaction runs the same
// zeroing sweep. A scan transaction reads the byte pair into the output stage
// via ST_SCAN_LD; the output stage then presents eight bytes, one per out
// transaction, while plots and clears go on behind it; a further scan waits
// until the previous eight bytes are all taken. Unknown actions and off-screen
// plots are accepted, leave the sequencer idle and change nothing.
module mono_framebuffer_gray_scanout (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         action,
  input  logic signed [11:0] pixel_x,
  input  logic signed [11:0] pixel_y,
  input  logic [1:0]         color_mode,
  input  logic [5:0]         column_pair,
  input  logic [2:0]         page_index,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         gray_byte,
  output logic               last_byte
);

  // sequencer states
  localparam logic [1:0] ST_CLEAR   = 2'd0;
  localparam logic [1:0] ST_IDLE    = 2'd1;
  localparam logic [1:0] ST_PLOT_WR = 2'd2;
  localparam logic [1:0] ST_SCAN_LD = 2'd3;

  logic [1:0]          state;
  logic [1:0]          state_next;
  mfgs_pkg::addr_t     clr_addr;
  mfgs_pkg::addr_t     plot_addr;
  logic                plot_odd;
  logic [7:0]          plot_mask;
  logic [1:0]          plot_mode;
  logic                scan_left_ok;
  logic                scan_right_ok;

  mfgs_pkg::mem_req_t   mem_req;
  mfgs_pkg::gray_load_t gray_ld;
  logic [7:0]           rd_even;
  logic [7:0]           rd_odd;
  logic                 gray_busy;

  logic                 in_acc;
  logic                 plot_hit;
  logic                 clr_done;
  mfgs_pkg::addr_t      in_plot_addr;
  mfgs_pkg::addr_t      in_scan_addr;
  logic [8:0]           left_col;
  logic                 left_ok;
  logic                 right_ok;
  logic [7:0]           old_byte;
  logic [7:0]           new_byte;

  // a scan has to wait for the output stage to drain; everything else only
  // waits for the sequencer
  assign in_stall = (state != ST_IDLE) || ((action == mfgs_pkg::ACT_SCAN) && gray_busy);
  assign in_acc   = in_valid && !in_stall;

  // plot lands on screen only for non-negative coordinates inside the frame
  assign plot_hit = !pixel_x[11] && ($unsigned(pixel_x) < 12'(mfgs_pkg::SCREEN_WIDTH)) &&
                    !pixel_y[11] && ($unsigned(pixel_y) < 12'(mfgs_pkg::SCREEN_HEIGHT));
  assign in_plot_addr = mfgs_pkg::bank_addr($unsigned(pixel_x),
                                            9'($unsigned(pixel_y) >> 3));

  // scan reads the even column from one bank and the odd one from the other
  assign left_col     = {2'b00, column_pair, 1'b0};
  assign left_ok      = (left_col < 9'(mfgs_pkg::SCREEN_WIDTH)) &&
                        (5'(page_index) < 5'(mfgs_pkg::PAGE_COUNT));
  assign right_ok     = ((left_col + 9'd1) < 9'(mfgs_pkg::SCREEN_WIDTH)) &&
                        (5'(page_index) < 5'(mfgs_pkg::PAGE_COUNT));
  assign in_scan_addr = mfgs_pkg::bank_addr({3'b000, left_col}, 9'(page_index));

  assign clr_done = (clr_addr == mfgs_pkg::ADDR_W'(mfgs_pkg::BANK_DEPTH - 1));

  // read-modify-write of the plotted byte
  assign old_byte = plot_odd ? rd_odd : rd_even;
  always_comb begin
    case (plot_mode)
      mfgs_pkg::MODE_SET:    new_byte = old_byte | plot_mask;
      mfgs_pkg::MODE_CLEAR:  new_byte = old_byte & ~plot_mask;
      mfgs_pkg::MODE_INVERT: new_byte = old_byte ^ plot_mask;
      default:               new_byte = old_byte;
    endcase
  end

  always_comb begin
    mem_req         = '0;
    mem_req.rd_addr = (action == mfgs_pkg::ACT_SCAN) ? in_scan_addr : in_plot_addr;
    mem_req.rd_en   = in_acc && (((action == mfgs_pkg::ACT_PLOT) && plot_hit) ||
                                 (action == mfgs_pkg::ACT_SCAN));
    gray_ld         = '0;
    gray_ld.left    = scan_left_ok ? rd_even : 8'h00;
    gray_ld.right   = scan_right_ok ? rd_odd : 8'h00;
    state_next      = state;
    case (state)
      ST_CLEAR: begin
        // zeroing sweep, one entry of each bank a cycle
        mem_req.wr_even = 1'b1;
        mem_req.wr_odd  = 1'b1;
        mem_req.wr_addr = clr_addr;
        mem_req.wr_data = 8'h00;
        if (clr_done) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (action)
            mfgs_pkg::ACT_PLOT:  state_next = plot_hit ? ST_PLOT_WR : ST_IDLE;
            mfgs_pkg::ACT_CLEAR: state_next = ST_CLEAR;
            mfgs_pkg::ACT_SCAN:  state_next = ST_SCAN_LD;
            default:             state_next = ST_IDLE;
          endcase
        end
      end
      ST_PLOT_WR: begin
        mem_req.wr_even = !plot_odd;
        mem_req.wr_odd  = plot_odd;
        mem_req.wr_addr = plot_addr;
        mem_req.wr_data = new_byte;
        state_next      = ST_IDLE;
      end
      ST_SCAN_LD: begin
        gray_ld.load = 1'b1;
        state_next   = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + mfgs_pkg::ADDR_W'(1);
      end else begin
        clr_addr <= '0;
      end
    end
  end

  // per-transaction payload captured at accept
  always_ff @(posedge clk) begin
    if (in_acc) begin
      plot_addr     <= in_plot_addr;
      plot_odd      <= pixel_x[0];
      plot_mask     <= 8'(8'd1 << pixel_y[2:0]);
      plot_mode     <= color_mode;
      scan_left_ok  <= left_ok;
      scan_right_ok <= right_ok;
    end
  end

  mfgs_frame_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_even (rd_even),
    .rd_odd  (rd_odd)
  );

  mfgs_gray_out u_gray (
    .clk       (clk),
    .rst       (rst),
    .ld        (gray_ld),
    .busy      (gray_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .gray_byte (gray_byte),
    .last_byte (last_byte)
  );

endmodule

// ----- rtl/mfgs_checker.sv -----
// port-level checks on the gray scan-out frame store, bound to the top level
// depends on mfgs_pkg and mono_framebuffer_gray_scanout_assert.svh
`include "mono_framebuffer_gray_scanout_assert.svh"

module mfgs_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic [1:0]         action,
  input logic               out_valid,
  input logic               out_stall,
  input logic [7:0]         gray_byte,
  input logic               last_byte
);

  // a stalled output transaction holds its bytes
  `MFGS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(gray_byte) && $stable(last_byte), "stalled output changed")

  // each nibble is fully dark or fully lit
  `MFGS_ASSERT_SAME(a_nibbles, out_valid, (gray_byte[7:4] == 4'h0 || gray_byte[7:4] == 4'hF) && (gray_byte[3:0] == 4'h0 || gray_byte[3:0] == 4'hF), "gray nibble not 0x0 or 0xF")

  // a clear keeps the input stalled in the following cycle for its sweep
  `MFGS_ASSERT_NEXT(a_busy_after, in_valid && !in_stall && (action == mfgs_pkg::ACT_CLEAR), in_stall, "input not stalled after clear")

  // a scan run ends with a gap before the next run
  `MFGS_ASSERT_NEXT(a_run_end, out_valid && !out_stall && last_byte, !out_valid, "output still valid after last byte")

endmodule

bind mono_framebuffer_gray_scanout mfgs_checker u_mfgs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .action    (action),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .gray_byte (gray_byte),
  .last_byte (last_byte)
);
